### hw/rtl/sptq_pkg.sv
package sptq_pkg;

	localparam int ID_W  = 8;
	localparam int PRI_W = 8;
	localparam int CMD_W = 3;
	localparam int ST_W  = 2;

	localparam logic [CMD_W-1:0] CMD_ENQUEUE = 3'd0;
	localparam logic [CMD_W-1:0] CMD_DEQUEUE = 3'd1;
	localparam logic [CMD_W-1:0] CMD_CANCEL  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_PROMOTE = 3'd3;
	localparam logic [CMD_W-1:0] CMD_RESUME  = 3'd4;

	localparam logic [ST_W-1:0] ST_OK       = 2'd0;
	localparam logic [ST_W-1:0] ST_EMPTY    = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL     = 2'd2;
	localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd3;

	localparam logic signed [PRI_W-1:0] PRI_MIN = -8'sd128;

	typedef struct packed {
		logic [ID_W-1:0]         id;
		logic signed [PRI_W-1:0] pri;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic [ST_W-1:0]         status;
		logic [ID_W-1:0]         pid;
		logic signed [PRI_W-1:0] ppri;
		logic                    yld;
	} result_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RD,
		S_EV,
		S_OUT
	} state_t;

	typedef enum logic [2:0] {
		OP_INS,
		OP_HEAD,
		OP_FIND,
		OP_REM,
		OP_PRO
	} op_t;

endpackage

### hw/rtl/sptq_ram.sv
module sptq_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### hw/rtl/stable_priority_task_queue.sv
// Sequencing: a command that needs no entry read (full enqueue, empty dequeue or resume,
// unknown code) goes straight from acceptance to the output state. Each entry read passes
// through a RAM read state and an evaluation state, and a scan that ends without a read
// passes through the read state once more before the output state.
// Handshake: one command at a time; the next is taken the cycle after the result registers.
// Reset: arst_n clears the entry count, the sequencer and the output valid; RAM is not cleared.
module stable_priority_task_queue
	import sptq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [CMD_W-1:0]         command,
	input  logic [ID_W-1:0]          task_id,
	input  logic signed [PRI_W-1:0]  task_priority,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [ST_W-1:0]          status,
	output logic [ID_W-1:0]          popped_id,
	output logic signed [PRI_W-1:0]  popped_priority,
	output logic                     yield_flag
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CW-1:0] FULL_C = CW'(QUEUE_DEPTH);
	localparam logic [CW-1:0] ONE_C  = CW'(1);

	state_t state_q, state_d;
	op_t    op_q, op_d;
	logic [CW-1:0] ptr_q, ptr_d;
	logic [CW-1:0] count_q, count_d;
	logic out_valid_q;

	logic [CMD_W-1:0]        cmd_q;
	logic [ID_W-1:0]         id_q;
	logic signed [PRI_W-1:0] pri_q;
	result_t res_q, res_d;
	result_t out_q;
	logic cap, out_load;

	logic          we, re;
	logic [AW-1:0] waddr, raddr;
	entry_t        wdata;
	logic [ENTRY_W-1:0] rdata;
	entry_t        rd_ent;
	logic          rd_gt;

	sptq_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign rd_ent = entry_t'(rdata);
	// The one shared priority comparator: stored priority against the command's priority.
	assign rd_gt  = rd_ent.pri > pri_q;

	always_comb begin
		state_d  = state_q;
		op_d     = op_q;
		ptr_d    = ptr_q;
		count_d  = count_q;
		res_d    = res_q;
		cap      = 1'b0;
		out_load = 1'b0;
		we       = 1'b0;
		re       = 1'b0;
		waddr    = '0;
		raddr    = '0;
		wdata    = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cap     = 1'b1;
					res_d   = '0;
					ptr_d   = '0;
					state_d = S_OUT;
					unique case (command)
						CMD_ENQUEUE: begin
							if (count_q == FULL_C) begin
								res_d.status = ST_FULL;
							end else begin
								op_d    = OP_INS;
								ptr_d   = count_q;
								state_d = S_RD;
							end
						end
						CMD_DEQUEUE: begin
							if (count_q == '0) begin
								res_d.status = ST_EMPTY;
							end else begin
								op_d    = OP_HEAD;
								state_d = S_RD;
							end
						end
						CMD_CANCEL, CMD_PROMOTE: begin
							op_d    = OP_FIND;
							state_d = S_RD;
						end
						CMD_RESUME: begin
							if (count_q != '0) begin
								op_d    = OP_HEAD;
								state_d = S_RD;
							end
						end
						default: ;
					endcase
				end
			end
			S_RD: begin
				state_d = S_EV;
				unique case (op_q)
					OP_INS: begin
						if (ptr_q == '0) begin
							we      = 1'b1;
							wdata   = '{id: id_q, pri: pri_q};
							count_d = count_q + ONE_C;
							state_d = S_OUT;
						end else begin
							re    = 1'b1;
							raddr = AW'(ptr_q - ONE_C);
						end
					end
					OP_HEAD: begin
						re = 1'b1;
					end
					OP_FIND: begin
						if (ptr_q == count_q) begin
							res_d.status = ST_NOTFOUND;
							state_d      = S_OUT;
						end else begin
							re    = 1'b1;
							raddr = AW'(ptr_q);
						end
					end
					OP_REM: begin
						if (CW'(ptr_q + ONE_C) >= count_q) begin
							count_d = count_q - ONE_C;
							state_d = S_OUT;
						end else begin
							re    = 1'b1;
							raddr = AW'(ptr_q + ONE_C);
						end
					end
					OP_PRO: begin
						if (ptr_q == '0) begin
							we      = 1'b1;
							wdata   = '{id: id_q, pri: PRI_MIN};
							state_d = S_OUT;
						end else begin
							re    = 1'b1;
							raddr = AW'(ptr_q - ONE_C);
						end
					end
				endcase
			end
			S_EV: begin
				state_d = S_RD;
				unique case (op_q)
					OP_INS: begin
						we    = 1'b1;
						waddr = AW'(ptr_q);
						if (rd_gt) begin
							wdata = rd_ent;
							ptr_d = ptr_q - ONE_C;
						end else begin
							wdata   = '{id: id_q, pri: pri_q};
							count_d = count_q + ONE_C;
							state_d = S_OUT;
						end
					end
					OP_HEAD: begin
						if (cmd_q == CMD_DEQUEUE) begin
							res_d.pid  = rd_ent.id;
							res_d.ppri = rd_ent.pri;
							op_d       = OP_REM;
							ptr_d      = '0;
						end else if (rd_gt) begin
							state_d = S_OUT;
						end else if (count_q == FULL_C) begin
							res_d.status = ST_FULL;
							state_d      = S_OUT;
						end else begin
							res_d.yld = 1'b1;
							op_d      = OP_INS;
							ptr_d     = count_q;
						end
					end
					OP_FIND: begin
						if (rd_ent.id == id_q) begin
							op_d = (cmd_q == CMD_CANCEL) ? OP_REM : OP_PRO;
						end else begin
							ptr_d = ptr_q + ONE_C;
						end
					end
					OP_REM: begin
						we    = 1'b1;
						waddr = AW'(ptr_q);
						wdata = rd_ent;
						ptr_d = ptr_q + ONE_C;
					end
					OP_PRO: begin
						we    = 1'b1;
						waddr = AW'(ptr_q);
						wdata = rd_ent;
						ptr_d = ptr_q - ONE_C;
					end
				endcase
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_INS;
			ptr_q       <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			ptr_q   <= ptr_d;
			count_q <= count_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
		if (cap) begin
			cmd_q <= command;
			id_q  <= task_id;
			pri_q <= task_priority;
		end
		if (out_load) begin
			out_q <= res_q;
		end
	end

	assign in_ready        = (state_q == S_IDLE);
	assign out_valid       = out_valid_q;
	assign status          = out_q.status;
	assign popped_id       = out_q.pid;
	assign popped_priority = out_q.ppri;
	assign yield_flag      = out_q.yld;

endmodule

### hw/rtl/sptq_checker.sv
module sptq_checker
	import sptq_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic [CMD_W-1:0]        command,
	input logic [ID_W-1:0]         task_id,
	input logic signed [PRI_W-1:0] task_priority,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic [ST_W-1:0]         status,
	input logic [ID_W-1:0]         popped_id,
	input logic signed [PRI_W-1:0] popped_priority,
	input logic                    yield_flag
);

	// A stalled result must hold until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(popped_id)
			&& $stable(popped_priority) && $stable(yield_flag))
		else $error("result changed while stalled");

	// Every command keeps the block busy in the cycle after acceptance.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready right after a transaction");

	// A yield only comes from a successful requeue, which reports nothing popped.
	a_yield: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && yield_flag |-> status == ST_OK && popped_id == '0
			&& popped_priority == '0)
		else $error("yield with a bad status or popped entry");

	// Failed commands report no popped entry.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_EMPTY || status == ST_FULL || status == ST_NOTFOUND)
			|-> popped_id == '0 && popped_priority == '0 && !yield_flag)
		else $error("failed command with nonzero result fields");

endmodule

bind stable_priority_task_queue sptq_checker u_sptq_checker (.*);
